// ===== hdl/avm_pkg.sv =====
// Shared types, constants and helpers for the ADPCM voice mixer.
// No dependencies; only the top level in hdl imports this package.
`timescale 1ns / 1ps

package avm_pkg;

  // Sizing
  localparam int RAM_BYTES   = 524288;
  localparam int RAM_AW      = $clog2(RAM_BYTES);
  localparam int HW_AW       = RAM_AW - 1;
  localparam int RAM_HW      = RAM_BYTES / 2;
  localparam int VOICE_COUNT = 24;
  localparam int VC_W        = 5;
  localparam int REG_COUNT   = 256;
  localparam int DEC_DEPTH   = VOICE_COUNT * 32;
  localparam int DEC_AW      = VC_W + 5;

  localparam logic [4:0] BLOCK_LEN = 5'd28;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DMA    = 2'd2,
    OP_RENDER = 2'd3
  } op_t;

  // Byte offsets with special meaning
  localparam logic [8:0] OFF_KON_LO  = 9'h188;
  localparam logic [8:0] OFF_KON_HI  = 9'h18A;
  localparam logic [8:0] OFF_KOFF_LO = 9'h18C;
  localparam logic [8:0] OFF_KOFF_HI = 9'h18E;
  localparam logic [8:0] OFF_MASK_LO = 9'h19C;
  localparam logic [8:0] OFF_MASK_HI = 9'h19E;
  localparam logic [8:0] OFF_XFER    = 9'h1A6;
  localparam logic [8:0] OFF_DATA    = 9'h1A8;
  localparam logic [8:0] OFF_STATUS  = 9'h1AE;

  localparam logic [15:0] STATUS_READY = 16'h0400;

  // Halfword indexes of global registers
  localparam logic [7:0] HW_MAIN_L = 8'hC0;
  localparam logic [7:0] HW_MAIN_R = 8'hC1;
  localparam logic [7:0] HW_CTRL   = 8'hD5;

  // Per-voice register slots
  localparam logic [2:0] VR_VOL_L  = 3'd0;
  localparam logic [2:0] VR_VOL_R  = 3'd1;
  localparam logic [2:0] VR_PITCH  = 3'd2;
  localparam logic [2:0] VR_START  = 3'd3;
  localparam logic [2:0] VR_REPEAT = 3'd7;

  localparam logic [13:0] PITCH_UNITY = 14'h1000;

  // Predictor coefficients
  localparam logic signed [7:0] COEF_A [5] = '{8'sd0, 8'sd60, 8'sd115, 8'sd98, 8'sd122};
  localparam logic signed [7:0] COEF_B [5] = '{8'sd0, 8'sd0, -8'sd52, -8'sd55, -8'sd60};

  // Volume register to signed gain: magnitude mode saturates, else 15-bit signed
  function automatic logic signed [16:0] vol_of(input logic [15:0] raw);
    logic signed [16:0] v;
    v = {2'b00, raw[14:0]};
    if (raw[15]) begin
      if (raw[14]) v = 17'sh3FFF;
    end else begin
      v = {{2{raw[14]}}, raw[14:0]};
    end
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
    logic signed [15:0] r;
    if (v > 42'sd32767) r = 16'sh7FFF;
    else if (v < -42'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hdl/avm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module avm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/adpcm_voice_mixer_with_registers.sv =====
// Top level of the ADPCM voice mixer: register file, sound RAM, voice sequencer.
// Depends on avm_pkg and avm_ram.
`timescale 1ns / 1ps
//
// Usage
//   Requests enter on the s_axis channel; tuser carries the kind (read, write,
//   DMA word, render frame), tdata the byte offset and the 32-bit data. Every
//   request gives exactly one response on m_axis: read data, and the stereo
//   frame for a render request (zero fields otherwise).
//   One request is worked at a time under a small sequencer that drives a
//   single shared multiplier and both ports of each memory.
// Work per request
//   Key-on steps through every voice and fetches the start and repeat
//   address of each keyed voice. Render stops after the control check when
//   output is disabled; else it visits all 24 voice slots, fetches and
//   mixes a sample for each playing voice, and first decodes a 28-sample
//   block for it when one is due. The decode loop (two multiplies and one
//   clamp per sample) sets the worst case.
// Reset
//   rst clears the sequencer state, transfer address and voice state, then a
//   clearing pass writes zero to every sound RAM halfword and register;
//   s_axis_tready stays low until it ends.
// Stall
//   A finished response waits in the output register while the next request
//   is already taken; the sequencer holds at its last step only if a second
//   response would overwrite one still not taken.
module adpcm_voice_mixer_with_registers
  import avm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [8:0] register_offset, [40:9] write_data, zero pad
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] read_data, [31:16] left, [47:32] right
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_RD_GET, S_DMA2,
    S_KON, S_KON_S, S_KON_R,
    S_R_CTL, S_R_CHK,
    S_V_BEGIN, S_V_FETCH, S_V_GOT, S_V_ML, S_V_MR, S_V_NEXT,
    S_DEC_INIT, S_DEC_RD, S_DEC_GET, S_DEC_MA, S_DEC_MB, S_DEC_SAMP, S_DEC_END,
    S_M_L, S_M_R, S_DONE
  } state_t;

  state_t state;

  // Request fields
  logic              accept;
  op_t               in_op;
  logic [8:0]        in_off;
  logic [31:0]       in_data;
  logic [15:0]       v16;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_op   = op_t'(s_axis_tuser);
  assign in_off  = s_axis_tdata[8:0];
  assign in_data = s_axis_tdata[40:9];
  assign v16     = in_data[15:0];
  assign s_axis_tready = (state == S_IDLE);

  // Control and per-voice state
  logic [HW_AW-1:0]       clr_cnt;
  logic [8:0]             off_q;
  logic [RAM_AW-1:0]      ta;
  logic                   dma_ok;
  logic [HW_AW-1:0]       dma_hw;
  logic [15:0]            dma_hi;
  logic [VOICE_COUNT-1:0] kmask;
  logic [VC_W-1:0]        vc;

  logic [VOICE_COUNT-1:0] active;
  logic [RAM_AW-1:0]      v_addr  [VOICE_COUNT];
  logic [RAM_AW-1:0]      v_rep   [VOICE_COUNT];
  logic [4:0]             v_idx   [VOICE_COUNT];
  logic [15:0]            v_phase [VOICE_COUNT];
  logic signed [15:0]     v_h1    [VOICE_COUNT];
  logic signed [15:0]     v_h2    [VOICE_COUNT];
  logic [2:0]             v_flags [VOICE_COUNT];

  // Decode working registers
  logic [RAM_AW-1:0]  blk;
  logic [2:0]         hw_cnt;
  logic [1:0]         nib_cnt;
  logic [4:0]         n_cnt;
  logic [15:0]        word;
  logic [3:0]         sh;
  logic [2:0]         fi;
  logic [7:0]         fl;
  logic signed [31:0] acc;

  // Mix registers
  logic signed [15:0] samp;
  logic signed [23:0] mixl, mixr;
  logic [15:0]        res_rd;
  logic signed [15:0] res_l, res_r;

  // Memories
  logic              snd_we;
  logic [HW_AW-1:0]  snd_waddr, snd_raddr;
  logic [15:0]       snd_wdata, snd_rdata;
  logic              reg_we;
  logic [7:0]        reg_waddr, reg_raddr;
  logic [15:0]       reg_wdata, reg_rdata;
  logic              dec_we;
  logic [DEC_AW-1:0] dec_waddr, dec_raddr;
  logic [15:0]       dec_wdata, dec_rdata;

  avm_ram #(.WIDTH(16), .DEPTH(RAM_HW)) u_snd_ram (
    .clk(clk), .we(snd_we), .waddr(snd_waddr), .wdata(snd_wdata),
    .raddr(snd_raddr), .rdata(snd_rdata)
  );

  avm_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_reg_ram (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  avm_ram #(.WIDTH(16), .DEPTH(DEC_DEPTH)) u_dec_ram (
    .clk(clk), .we(dec_we), .waddr(dec_waddr), .wdata(dec_wdata),
    .raddr(dec_raddr), .rdata(dec_rdata)
  );

  // Shared multiplier
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] prod;
  logic signed [40:0] prod_sh;

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> 14;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DEC_MA: begin
        mul_a = 24'(v_h1[vc]);
        mul_b = 17'(COEF_A[fi]);
      end
      S_DEC_MB: begin
        mul_a = 24'(v_h2[vc]);
        mul_b = 17'(COEF_B[fi]);
      end
      S_V_ML, S_V_MR: begin
        mul_a = 24'(samp);
        mul_b = vol_of(reg_rdata);
      end
      S_M_L: begin
        mul_a = mixl;
        mul_b = vol_of(reg_rdata);
      end
      S_M_R: begin
        mul_a = mixr;
        mul_b = vol_of(reg_rdata);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Status masks and key masks
  logic [31:0]            act32;
  logic [31:0]            key32;
  logic [VOICE_COUNT-1:0] key_mask;

  assign act32 = 32'(active);
  assign key32 = (in_off == OFF_KON_LO || in_off == OFF_KOFF_LO) ? {16'h0, v16} : {v16, 16'h0};
  assign key_mask = key32[VOICE_COUNT-1:0];

  // Transfer address arithmetic
  logic [19:0]       ta_set;
  logic              dma_fits;
  assign ta_set   = {1'b0, v16, 3'b000};
  assign dma_fits = ({1'b0, ta} + 20'd3) < 20'(RAM_BYTES);

  // Voice pitch step
  logic [13:0] pitch;
  logic [16:0] ph_sum;
  logic [4:0]  ph_k;
  logic [4:0]  ph_rem;
  assign pitch  = (reg_rdata[13:0] == 14'd0) ? PITCH_UNITY : reg_rdata[13:0];
  assign ph_sum = {1'b0, v_phase[vc]} + {3'b000, pitch};
  assign ph_k   = ph_sum[16:12];
  assign ph_rem = BLOCK_LEN - v_idx[vc];

  // Block start, sample reconstruction
  logic [18:0]        reg_byte;
  logic [19:0]        blk_end;
  logic signed [3:0]  nib;
  logic signed [15:0] nib_term;
  logic signed [31:0] pred_term;
  logic signed [15:0] dec_sample;

  assign reg_byte  = {reg_rdata, 3'b000};
  assign blk_end   = 20'(v_addr[vc]) + 20'd16;
  assign nib       = word[{nib_cnt, 2'b00} +: 4];
  assign nib_term  = $signed({nib, 12'h000}) >>> sh;
  assign pred_term = (acc + 32'sd32) >>> 6;
  assign dec_sample = sat16(42'(32'(nib_term) + pred_term));

  // Memory ports
  always_comb begin
    snd_we    = 1'b0;
    snd_waddr = ta[RAM_AW-1:1];
    snd_wdata = v16;
    if (state == S_CLEAR) begin
      snd_we    = 1'b1;
      snd_waddr = clr_cnt;
      snd_wdata = '0;
    end else if (state == S_DMA2) begin
      snd_we    = dma_ok;
      snd_waddr = dma_hw;
      snd_wdata = dma_hi;
    end else if (accept && in_op == OP_WRITE && in_off == OFF_DATA) begin
      snd_we    = 1'b1;
    end else if (accept && in_op == OP_DMA) begin
      snd_we    = dma_fits;
      snd_wdata = in_data[15:0];
    end
  end

  assign snd_raddr = blk[RAM_AW-1:1] + HW_AW'(hw_cnt);

  always_comb begin
    reg_we    = 1'b0;
    reg_waddr = in_off[8:1];
    reg_wdata = v16;
    if (state == S_CLEAR) begin
      reg_we    = (clr_cnt[HW_AW-1:8] == '0);
      reg_waddr = clr_cnt[7:0];
      reg_wdata = '0;
    end else if (accept && in_op == OP_WRITE) begin
      reg_we    = 1'b1;
    end
  end

  always_comb begin
    case (state)
      S_RD:      reg_raddr = off_q[8:1];
      S_KON:     reg_raddr = {vc, VR_START};
      S_KON_S:   reg_raddr = {vc, VR_REPEAT};
      S_V_FETCH: reg_raddr = {vc, VR_PITCH};
      S_V_GOT:   reg_raddr = {vc, VR_VOL_L};
      S_V_ML:    reg_raddr = {vc, VR_VOL_R};
      S_V_NEXT:  reg_raddr = HW_MAIN_L;
      S_M_L:     reg_raddr = HW_MAIN_R;
      default:   reg_raddr = HW_CTRL;
    endcase
  end

  assign dec_we    = (state == S_DEC_SAMP);
  assign dec_waddr = {vc, n_cnt};
  assign dec_wdata = dec_sample;
  assign dec_raddr = {vc, v_idx[vc]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      ta            <= '0;
      active        <= '0;
      vc            <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        v_addr[i]  <= '0;
        v_rep[i]   <= '0;
        v_idx[i]   <= '0;
        v_phase[i] <= '0;
        v_h1[i]    <= '0;
        v_h2[i]    <= '0;
        v_flags[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            res_rd <= '0;
            res_l  <= '0;
            res_r  <= '0;
            off_q  <= in_off;
            case (in_op)
              OP_READ: begin
                if (in_off == OFF_STATUS) begin
                  res_rd <= STATUS_READY;
                  state  <= S_DONE;
                end else if (in_off == OFF_MASK_LO) begin
                  res_rd <= act32[15:0];
                  state  <= S_DONE;
                end else if (in_off == OFF_MASK_HI) begin
                  res_rd <= act32[31:16];
                  state  <= S_DONE;
                end else begin
                  state <= S_RD;
                end
              end
              OP_WRITE: begin
                state <= S_DONE;
                if (in_off == OFF_KON_LO || in_off == OFF_KON_HI) begin
                  kmask <= key_mask;
                  vc    <= '0;
                  state <= S_KON;
                end
                if (in_off == OFF_KOFF_LO || in_off == OFF_KOFF_HI) begin
                  active <= active & ~key_mask;
                end
                if (in_off == OFF_XFER) begin
                  ta <= (ta_set >= 20'(RAM_BYTES)) ? '0 : ta_set[RAM_AW-1:0];
                end
                if (in_off == OFF_DATA) begin
                  ta <= ta + RAM_AW'(2);
                end
              end
              OP_DMA: begin
                dma_ok <= dma_fits;
                dma_hw <= ta[RAM_AW-1:1] + 1'b1;
                dma_hi <= in_data[31:16];
                ta     <= ta + RAM_AW'(4);
                state  <= S_DMA2;
              end
              default: begin
                state <= S_R_CTL;
              end
            endcase
          end
        end
        S_RD: state <= S_RD_GET;
        S_RD_GET: begin
          res_rd <= reg_rdata;
          state  <= S_DONE;
        end
        S_DMA2: state <= S_DONE;
        // Key-on: fetch start and repeat address for each keyed voice
        S_KON: begin
          if (kmask[vc]) begin
            state <= S_KON_S;
          end else if (vc == VC_W'(VOICE_COUNT - 1)) begin
            state <= S_DONE;
          end else begin
            vc <= vc + 1'b1;
          end
        end
        S_KON_S: begin
          v_addr[vc] <= reg_byte[RAM_AW-1:0];
          state      <= S_KON_R;
        end
        S_KON_R: begin
          v_rep[vc]   <= reg_byte[RAM_AW-1:0];
          active[vc]  <= 1'b1;
          v_idx[vc]   <= BLOCK_LEN;
          v_phase[vc] <= '0;
          v_h1[vc]    <= '0;
          v_h2[vc]    <= '0;
          v_flags[vc] <= '0;
          if (vc == VC_W'(VOICE_COUNT - 1)) begin
            state <= S_DONE;
          end else begin
            vc    <= vc + 1'b1;
            state <= S_KON;
          end
        end
        // Render
        S_R_CTL: state <= S_R_CHK;
        S_R_CHK: begin
          if (reg_rdata[15]) begin
            vc    <= '0;
            mixl  <= '0;
            mixr  <= '0;
            state <= S_V_BEGIN;
          end else begin
            state <= S_DONE;
          end
        end
        S_V_BEGIN: begin
          if (!active[vc]) begin
            state <= S_V_NEXT;
          end else if (v_idx[vc] >= BLOCK_LEN) begin
            if (v_flags[vc][0] && !v_flags[vc][1]) begin
              active[vc] <= 1'b0;
              state      <= S_V_NEXT;
            end else begin
              if (v_flags[vc][0]) v_addr[vc] <= v_rep[vc];
              state <= S_DEC_INIT;
            end
          end else begin
            state <= S_V_FETCH;
          end
        end
        S_DEC_INIT: begin
          blk    <= (blk_end > 20'(RAM_BYTES)) ? '0 : v_addr[vc];
          hw_cnt <= '0;
          n_cnt  <= '0;
          state  <= S_DEC_RD;
        end
        S_DEC_RD: state <= S_DEC_GET;
        S_DEC_GET: begin
          word <= snd_rdata;
          if (hw_cnt == 3'd0) begin
            sh     <= (snd_rdata[3:0] > 4'd12) ? 4'd12 : snd_rdata[3:0];
            fi     <= (snd_rdata[7:4] > 4'd4) ? 3'd0 : snd_rdata[6:4];
            fl     <= snd_rdata[15:8];
            hw_cnt <= 3'd1;
            state  <= S_DEC_RD;
          end else begin
            nib_cnt <= '0;
            state   <= S_DEC_MA;
          end
        end
        S_DEC_MA: begin
          acc   <= 32'(prod);
          state <= S_DEC_MB;
        end
        S_DEC_MB: begin
          acc   <= acc + 32'(prod);
          state <= S_DEC_SAMP;
        end
        S_DEC_SAMP: begin
          v_h2[vc] <= v_h1[vc];
          v_h1[vc] <= dec_sample;
          n_cnt    <= n_cnt + 1'b1;
          if (nib_cnt == 2'd3) begin
            if (hw_cnt == 3'd7) begin
              state <= S_DEC_END;
            end else begin
              hw_cnt <= hw_cnt + 1'b1;
              state  <= S_DEC_RD;
            end
          end else begin
            nib_cnt <= nib_cnt + 1'b1;
            state   <= S_DEC_MA;
          end
        end
        S_DEC_END: begin
          if (fl[2]) v_rep[vc] <= blk;
          v_flags[vc] <= fl[2:0];
          v_idx[vc]   <= '0;
          v_addr[vc]  <= blk + RAM_AW'(16);
          state       <= S_V_FETCH;
        end
        S_V_FETCH: state <= S_V_GOT;
        S_V_GOT: begin
          samp <= dec_rdata;
          if (ph_k >= ph_rem) begin
            v_idx[vc]   <= BLOCK_LEN;
            v_phase[vc] <= 16'(ph_sum - {ph_rem, 12'h000});
          end else begin
            v_idx[vc]   <= v_idx[vc] + ph_k;
            v_phase[vc] <= {4'h0, ph_sum[11:0]};
          end
          state <= S_V_ML;
        end
        S_V_ML: begin
          mixl  <= mixl + 24'(prod_sh);
          state <= S_V_MR;
        end
        S_V_MR: begin
          mixr  <= mixr + 24'(prod_sh);
          state <= S_V_NEXT;
        end
        S_V_NEXT: begin
          if (vc == VC_W'(VOICE_COUNT - 1)) begin
            state <= S_M_L;
          end else begin
            vc    <= vc + 1'b1;
            state <= S_V_BEGIN;
          end
        end
        S_M_L: begin
          res_l <= sat16(42'(prod_sh));
          state <= S_M_R;
        end
        S_M_R: begin
          res_r <= sat16(42'(prod_sh));
          state <= S_DONE;
        end
        S_DONE: begin
          // hold while an earlier response is still waiting
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {res_r, res_l, res_rd};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/avm_checker.sv =====
// Port-level checks for the ADPCM voice mixer, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module avm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // the clearing pass keeps requests out after reset
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request taken or response shown right after reset");

  // one request at a time: busy the cycle after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken back to back");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled response changed or dropped");

  a_resp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("response withdrawn without being taken");

endmodule

bind adpcm_voice_mixer_with_registers avm_checker u_avm_checker (.*);
